// File: rtl/tccw_pkg.sv
package tccw_pkg;

   localparam int COLUMNS     = 80;
   localparam int ROWS        = 25;
   localparam int CELLS       = COLUMNS * ROWS;
   localparam int COL_W       = 7;
   localparam int LINE_W      = 5;
   localparam int ADDR_W      = 11;
   localparam int CHAR_W      = 8;
   localparam int ATTR_W      = 8;
   localparam int COLOR_W     = 4;
   localparam int CELL_W      = CHAR_W + ATTR_W;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCNT_W      = 2;

   localparam logic [COL_W-1:0]   COL_MAX       = COL_W'(COLUMNS - 1);
   localparam logic [COL_W-1:0]   COL_LIMIT     = COL_W'(COLUMNS);
   localparam logic [LINE_W-1:0]  LINE_MAX      = LINE_W'(ROWS - 1);
   localparam logic [ADDR_W-1:0]  CELLS_END     = ADDR_W'(CELLS);
   localparam logic [ADDR_W-1:0]  LAST_CELL     = ADDR_W'(CELLS - 1);
   localparam logic [ADDR_W-1:0]  ROW_SPAN      = ADDR_W'(COLUMNS);
   localparam logic [ADDR_W-1:0]  LAST_ROW_BASE = ADDR_W'((ROWS - 1) * COLUMNS);

   localparam logic [CHAR_W-1:0]  BLANK_CHAR    = 8'h20;
   localparam logic [CHAR_W-1:0]  NEWLINE_CHAR  = 8'h0A;
   localparam logic [COLOR_W-1:0] FG_RESET      = 4'd14;
   localparam logic [COLOR_W-1:0] BG_RESET      = 4'd8;

   typedef enum logic [1:0] {
      CMD_PUT   = 2'd0,
      CMD_CLEAR = 2'd1,
      CMD_SET   = 2'd2,
      CMD_READ  = 2'd3
   } command_type;

   typedef enum logic {
      CSR_FOREGROUND = 1'b0,
      CSR_BACKGROUND = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      OP_PUT_CHAR,
      OP_NEWLINE,
      OP_CLEAR,
      OP_SET,
      OP_READ
   } op_kind_type;

   typedef struct packed {
      command_type        command;
      logic [CHAR_W-1:0]  character;
      logic [COL_W-1:0]   column_in;
      logic [LINE_W-1:0]  line_in;
   } req_type;

   typedef struct packed {
      logic [COL_W-1:0]   cursor_column_out;
      logic [LINE_W-1:0]  cursor_line_out;
      logic [ADDR_W-1:0]  cursor_offset;
      logic [CHAR_W-1:0]  read_character;
      logic [ATTR_W-1:0]  read_attribute;
   } rsp_type;

   typedef struct packed {
      op_kind_type        kind;
      logic [CHAR_W-1:0]  character;
      logic [COL_W-1:0]   column;
      logic [LINE_W-1:0]  line;
      logic [ADDR_W-1:0]  addr;
   } cmd_item_type;

   typedef struct packed {
      logic               valid;
      logic               full;
   } queue_status_type;

   typedef struct packed {
      logic               init_busy;
   } back_status_type;

   function automatic logic [ADDR_W-1:0] cell_addr(input logic [LINE_W-1:0] row,
                                                   input logic [COL_W-1:0] col);
      return ADDR_W'(row) * ROW_SPAN + ADDR_W'(col);
   endfunction

endpackage

// File: rtl/tccw_front.sv
module tccw_front import tccw_pkg::*; (
   input  logic             start,
   input  req_type          req_payload,
   input  queue_status_type q_status,
   input  back_status_type  back_status,
   output logic             busy,
   output logic             push,
   output cmd_item_type     push_item
);

   logic [COL_W-1:0]  col_c;
   logic [LINE_W-1:0] line_c;

   assign busy = q_status.full | back_status.init_busy;
   assign push = start & ~busy;

   always_comb begin
      col_c  = (req_payload.column_in > COL_MAX) ? COL_MAX : req_payload.column_in;
      line_c = (req_payload.line_in > LINE_MAX) ? LINE_MAX : req_payload.line_in;
      push_item.character = req_payload.character;
      push_item.column    = col_c;
      push_item.line      = line_c;
      push_item.addr      = cell_addr(line_c, col_c);
      case (req_payload.command)
         CMD_PUT: begin
            push_item.kind = (req_payload.character == NEWLINE_CHAR) ? OP_NEWLINE
                                                                     : OP_PUT_CHAR;
         end
         CMD_CLEAR: push_item.kind = OP_CLEAR;
         CMD_SET:   push_item.kind = OP_SET;
         CMD_READ:  push_item.kind = OP_READ;
         default:   push_item.kind = OP_SET;
      endcase
   end

endmodule

// File: rtl/tccw_queue.sv
module tccw_queue import tccw_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  cmd_item_type     push_item,
   input  logic             pop,
   output queue_status_type q_status,
   output cmd_item_type     head_item
);

   cmd_item_type      entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push, do_pop;

   assign q_status.valid = (count_ff != '0);
   assign q_status.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_item      = entry_ff[rd_ptr_ff];
   assign do_push        = push & ~q_status.full;
   assign do_pop         = pop & q_status.valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: rtl/tccw_back.sv
module tccw_back import tccw_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic [ATTR_W-1:0] attr,
   input  queue_status_type  q_status,
   input  cmd_item_type      head_item,
   output logic              pop,
   output back_status_type   back_status,
   output logic              rsp_strobe,
   output rsp_type           rsp_payload
);

   typedef enum logic [2:0] {
      S_INIT,
      S_IDLE,
      S_RESP,
      S_COPY,
      S_FILL
   } state_type;

   state_type         state_ff, state_in;
   logic [COL_W-1:0]  cur_col_ff, cur_col_in;
   logic [LINE_W-1:0] cur_line_ff, cur_line_in;
   logic [ADDR_W-1:0] cnt_ff, cnt_in;
   logic [ADDR_W-1:0] wa_ff, wa_in;
   logic              copy_pend_ff, copy_pend_in;
   logic              pend_char_ff, pend_char_in;
   logic [CHAR_W-1:0] char_ff, char_in;
   logic              is_read_ff, is_read_in;
   logic [CELL_W-1:0] rd_q_ff;
   logic [CELL_W-1:0] mem [CELLS];

   logic              mem_we;
   logic [ADDR_W-1:0] mem_wa, mem_ra;
   logic [CELL_W-1:0] mem_wd;
   logic              need_nl;
   logic [COL_W-1:0]  nl_col;
   logic [LINE_W-1:0] nl_line;

   assign back_status.init_busy = (state_ff == S_INIT);
   assign rsp_strobe            = (state_ff == S_RESP);

   always_comb begin
      rsp_payload.cursor_column_out = cur_col_ff;
      rsp_payload.cursor_line_out   = cur_line_ff;
      rsp_payload.cursor_offset     = cell_addr(cur_line_ff, cur_col_ff);
      rsp_payload.read_character    = is_read_ff ? rd_q_ff[CHAR_W-1:0] : '0;
      rsp_payload.read_attribute    = is_read_ff ? rd_q_ff[CELL_W-1:CHAR_W] : '0;
   end

   always_comb begin
      state_in     = state_ff;
      cur_col_in   = cur_col_ff;
      cur_line_in  = cur_line_ff;
      cnt_in       = cnt_ff;
      wa_in        = wa_ff;
      copy_pend_in = copy_pend_ff;
      pend_char_in = pend_char_ff;
      char_in      = char_ff;
      is_read_in   = is_read_ff;
      pop          = 1'b0;
      mem_we       = 1'b0;
      mem_wa       = cnt_ff;
      mem_wd       = '0;
      mem_ra       = cnt_ff;
      need_nl      = (head_item.kind == OP_NEWLINE) || (cur_col_ff >= COL_LIMIT);
      nl_col       = need_nl ? '0 : cur_col_ff;
      nl_line      = need_nl ? cur_line_ff + 1'b1 : cur_line_ff;

      case (state_ff)
         S_INIT: begin
            mem_we = 1'b1;
            if (cnt_ff == LAST_CELL) begin
               state_in = S_IDLE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_IDLE: begin
            mem_ra = head_item.addr;
            if (q_status.valid) begin
               pop        = 1'b1;
               is_read_in = 1'b0;
               char_in    = head_item.character;
               case (head_item.kind)
                  OP_SET: begin
                     cur_col_in  = head_item.column;
                     cur_line_in = head_item.line;
                     state_in    = S_RESP;
                  end
                  OP_READ: begin
                     is_read_in = 1'b1;
                     state_in   = S_RESP;
                  end
                  OP_CLEAR: begin
                     pend_char_in = 1'b0;
                     cnt_in       = '0;
                     state_in     = S_FILL;
                  end
                  OP_PUT_CHAR, OP_NEWLINE: begin
                     if (need_nl && cur_line_ff == LINE_MAX) begin
                        // scroll: cursor rests on the last row, char lands at column 0
                        pend_char_in = (head_item.kind == OP_PUT_CHAR);
                        cur_col_in   = (head_item.kind == OP_PUT_CHAR) ? COL_W'(1) : '0;
                        cnt_in       = ROW_SPAN;
                        copy_pend_in = 1'b0;
                        state_in     = S_COPY;
                     end else begin
                        cur_line_in = nl_line;
                        cur_col_in  = nl_col;
                        if (head_item.kind == OP_PUT_CHAR) begin
                           mem_we     = 1'b1;
                           mem_wa     = cell_addr(nl_line, nl_col);
                           mem_wd     = {attr, head_item.character};
                           cur_col_in = nl_col + 1'b1;
                        end
                        state_in = S_RESP;
                     end
                  end
                  default: state_in = S_RESP;
               endcase
            end
         end
         S_RESP: begin
            state_in = S_IDLE;
         end
         S_COPY: begin
            // read one row ahead, write the previous read one row up
            mem_we = copy_pend_ff;
            mem_wa = wa_ff;
            mem_wd = rd_q_ff;
            if (cnt_ff == CELLS_END) begin
               copy_pend_in = 1'b0;
               cnt_in       = LAST_ROW_BASE;
               state_in     = S_FILL;
            end else begin
               copy_pend_in = 1'b1;
               wa_in        = cnt_ff - ROW_SPAN;
               cnt_in       = cnt_ff + 1'b1;
            end
         end
         S_FILL: begin
            mem_we = 1'b1;
            mem_wd = (pend_char_ff && cnt_ff == LAST_ROW_BASE) ? {attr, char_ff}
                                                               : {attr, BLANK_CHAR};
            if (cnt_ff == LAST_CELL) begin
               pend_char_in = 1'b0;
               state_in     = S_RESP;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_q_ff <= mem[mem_ra];
   end

   always_ff @(posedge clock) begin
      wa_ff   <= wa_in;
      char_ff <= char_in;
      if (reset) begin
         state_ff     <= S_INIT;
         cur_col_ff   <= '0;
         cur_line_ff  <= '0;
         cnt_ff       <= '0;
         copy_pend_ff <= 1'b0;
         pend_char_ff <= 1'b0;
         is_read_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_col_ff   <= cur_col_in;
         cur_line_ff  <= cur_line_in;
         cnt_ff       <= cnt_in;
         copy_pend_ff <= copy_pend_in;
         pend_char_ff <= pend_char_in;
         is_read_ff   <= is_read_in;
      end
   end

endmodule

// File: rtl/text_console_cell_writer.sv
// Channel   Handshake          Payload          Direction
// request   start / busy       req_payload      in
// response  rsp_strobe         rsp_payload      out
// csr       csr_we             csr_index/wdata  in
//
// Put, set and read pass through a queue pop, then a response; the back end
// runs one request at a time against the single-write cell memory.
// Scroll copies every row up one and blanks the last row; clear blanks every cell.
// After reset a clearing pass zeroes the cells; busy is high.
// busy also rises while the two-entry request queue is full.
// The receiver cannot stall: each response shows for exactly one cycle.
module text_console_cell_writer import tccw_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  req_type            req_payload,
   output logic               busy,
   output logic               rsp_strobe,
   output rsp_type            rsp_payload,
   input  logic               csr_we,
   input  csr_index_type      csr_index,
   input  logic [COLOR_W-1:0] csr_wdata
);

   // colour registers; the user must write them only while idle (the block has no guard for it)
   logic [COLOR_W-1:0] fg_ff, fg_in;
   logic [COLOR_W-1:0] bg_ff, bg_in;
   logic [ATTR_W-1:0]  attr;

   logic              push;
   logic              pop;
   cmd_item_type      push_item;
   cmd_item_type      head_item;
   queue_status_type  q_status;
   back_status_type   back_status;

   // attribute: background high nibble, foreground low nibble
   assign attr = {bg_ff, fg_ff};

   always_comb begin
      fg_in = fg_ff;
      bg_in = bg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_FOREGROUND: fg_in = csr_wdata;
            CSR_BACKGROUND: bg_in = csr_wdata;
            default: begin
               fg_in = fg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fg_ff <= FG_RESET;
         bg_ff <= BG_RESET;
      end else begin
         fg_ff <= fg_in;
         bg_ff <= bg_in;
      end
   end

   // front: clamp coordinates, classify the request, push into the queue
   tccw_front u_front (
      .start       (start),
      .req_payload (req_payload),
      .q_status    (q_status),
      .back_status (back_status),
      .busy        (busy),
      .push        (push),
      .push_item   (push_item)
   );

   // hold classified requests so the front keeps accepting during short work
   tccw_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .q_status  (q_status),
      .head_item (head_item)
   );

   // back: set or advance the cursor, write, read, scroll and clear the cell memory
   tccw_back u_back (
      .clock       (clock),
      .reset       (reset),
      .attr        (attr),
      .q_status    (q_status),
      .head_item   (head_item),
      .pop         (pop),
      .back_status (back_status),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

endmodule

// File: rtl/tccw_checker.sv
module tccw_checker import tccw_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    busy,
   input logic    rsp_strobe,
   input rsp_type rsp_payload
);

   a_quiet_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_strobe && busy)
      else $error("response or ready straight after reset");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("two responses in consecutive cycles");

   a_position: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_payload.cursor_offset ==
         ADDR_W'(rsp_payload.cursor_line_out) * ROW_SPAN
         + ADDR_W'(rsp_payload.cursor_column_out))
      else $error("cursor position disagrees with column and line");

   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_payload.cursor_line_out <= LINE_MAX
                     && rsp_payload.cursor_column_out <= COL_LIMIT)
      else $error("cursor outside the screen");

endmodule

bind text_console_cell_writer tccw_checker u_tccw_checker (
   .clock       (clock),
   .reset       (reset),
   .busy        (busy),
   .rsp_strobe  (rsp_strobe),
   .rsp_payload (rsp_payload)
);

// File: verif/text_console_cell_writer_tb.sv
`timescale 1ns / 1ps

module text_console_cell_writer_tb;
   import tccw_pkg::*;

   // A scroll or a clear walks the whole store, and a second one may sit in the
   // request queue behind it, so allow several times such a walk before calling
   // the run hung.
   localparam int IDLE_LIMIT    = 20000;
   localparam int SETTLE_CYCLES = 16;
   localparam int RANDOM_ITEMS  = 1300;
   localparam int MAX_GAP       = 12;

   logic               clock;
   logic               reset;
   logic               start;
   req_type            req_payload;
   logic               busy;
   logic               rsp_strobe;
   rsp_type            rsp_payload;
   logic               csr_we;
   csr_index_type      csr_index;
   logic [COLOR_W-1:0] csr_wdata;

   text_console_cell_writer dut (.*);

   // Predicted screen: one character and one attribute per cell, plus the
   // cursor and the colour registers as the block should hold them.
   logic [CHAR_W-1:0]  screen_char [CELLS];
   logic [ATTR_W-1:0]  screen_attr [CELLS];
   logic [COL_W-1:0]   model_col;
   logic [LINE_W-1:0]  model_line;
   logic [COLOR_W-1:0] fg_colour;
   logic [COLOR_W-1:0] bg_colour;

   // Cursor reports still owed by the block, oldest first.
   rsp_type expected_reports [$];

   int errors        = 0;
   int requests_sent = 0;
   int puts_done     = 0;
   int newlines_done = 0;
   int wraps_done    = 0;
   int scrolls_done  = 0;
   int clears_done   = 0;
   int sets_done     = 0;
   int reads_done    = 0;
   int colour_writes = 0;
   int idle_cycles   = 0;
   bit no_gaps       = 1'b0;

   // ------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------

   function automatic logic [ATTR_W-1:0] current_attribute();
      return {bg_colour, fg_colour};
   endfunction

   // Return to column 0 on the next line; from the last row, move every row
   // up by one (column 0 included) and blank the last row.
   function automatic void model_newline();
      model_col = '0;
      if (model_line < LINE_MAX) begin
         model_line++;
      end else begin
         scrolls_done++;
         for (int i = COLUMNS; i < CELLS; i++) begin
            screen_char[i - COLUMNS] = screen_char[i];
            screen_attr[i - COLUMNS] = screen_attr[i];
         end
         for (int i = CELLS - COLUMNS; i < CELLS; i++) begin
            screen_char[i] = BLANK_CHAR;
            screen_attr[i] = current_attribute();
         end
      end
   endfunction

   // Apply one request to the predicted screen and return the cursor report
   // that the block owes for it.
   function automatic rsp_type predict_cursor_report(input req_type r);
      rsp_type rep;
      int      col;
      int      row;
      int      idx;
      rep = '0;
      col = (r.column_in > COL_MAX) ? COL_MAX : r.column_in;
      row = (r.line_in > LINE_MAX) ? LINE_MAX : r.line_in;
      case (r.command)
         CMD_PUT: begin
            puts_done++;
            if (r.character == NEWLINE_CHAR) begin
               newlines_done++;
               model_newline();
            end else begin
               // a column resting at the limit wraps before the byte lands
               if (model_col >= COL_LIMIT) begin
                  wraps_done++;
                  model_newline();
               end
               idx = int'(model_line) * COLUMNS + int'(model_col);
               screen_char[idx] = r.character;
               screen_attr[idx] = current_attribute();
               model_col++;
            end
         end
         CMD_CLEAR: begin
            clears_done++;
            for (int i = 0; i < CELLS; i++) begin
               screen_char[i] = BLANK_CHAR;
               screen_attr[i] = current_attribute();
            end
         end
         CMD_SET: begin
            sets_done++;
            model_col  = COL_W'(col);
            model_line = LINE_W'(row);
         end
         CMD_READ: begin
            reads_done++;
            idx = row * COLUMNS + col;
            rep.read_character = screen_char[idx];
            rep.read_attribute = screen_attr[idx];
         end
      endcase
      rep.cursor_column_out = model_col;
      rep.cursor_line_out   = model_line;
      rep.cursor_offset     = ADDR_W'(int'(model_col) + COLUMNS * int'(model_line));
      return rep;
   endfunction

   // ------------------------------------------------------------------
   // Shared driving tasks
   // ------------------------------------------------------------------

   // Offer one request after a random hold-off and wait until the block takes
   // it. Start stays high between back-to-back requests.
   task automatic send_request(input command_type       cmd,
                               input logic [CHAR_W-1:0] ch,
                               input logic [COL_W-1:0]  col,
                               input logic [LINE_W-1:0] row);
      req_type r;
      int      gap;
      r.command   = cmd;
      r.character = ch;
      r.column_in = col;
      r.line_in   = row;
      gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start       <= 1'b1;
      req_payload <= r;
      // accepted at the first edge that sees start high and busy low
      do @(posedge clock); while (busy);
      expected_reports.push_back(predict_cursor_report(r));
      requests_sent++;
   endtask

   // Drop start, wait for every owed report and for the back end to go quiet,
   // then leave a few spare cycles. Poll on the falling edge so the checker's
   // pops at the rising edge never race with the test.
   task automatic drain_reports();
      start <= 1'b0;
      while (expected_reports.size() != 0) @(negedge clock);
      while (busy) @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write both colour registers on consecutive edges; only call while idle.
   task automatic write_colours(input logic [COLOR_W-1:0] fg,
                                input logic [COLOR_W-1:0] bg);
      csr_we    <= 1'b1;
      csr_index <= CSR_FOREGROUND;
      csr_wdata <= fg;
      @(posedge clock);
      csr_index <= CSR_BACKGROUND;
      csr_wdata <= bg;
      @(posedge clock);
      csr_we    <= 1'b0;
      fg_colour = fg;
      bg_colour = bg;
      colour_writes++;
   endtask

   // ------------------------------------------------------------------
   // Test tasks
   // ------------------------------------------------------------------

   // Cells come out of reset zeroed; probe the corners (the second read is
   // clamped onto the last cell) and write once with the reset colours.
   task automatic test_reset_state();
      send_request(CMD_READ, 8'hFF, 7'd0, 5'd0);
      send_request(CMD_READ, 8'h00, 7'h7F, 5'h1F);
      send_request(CMD_PUT, 8'h41, 7'd0, 5'd0);
      send_request(CMD_READ, 8'h00, 7'd0, 5'd0);
   endtask

   // Fill the end of a row so the column rests at the limit, then wrap on the
   // next byte; finish with a newline from near the start of the next row.
   task automatic test_line_wrap();
      send_request(CMD_SET, 8'h00, COL_MAX - 7'd1, 5'd0);
      send_request(CMD_PUT, 8'hFF, 7'h7F, 5'h1F);
      send_request(CMD_PUT, 8'h00, 7'd0, 5'd0);
      send_request(CMD_PUT, 8'h5A, 7'd0, 5'd0);
      send_request(CMD_READ, 8'h00, COL_MAX, 5'd0);
      send_request(CMD_READ, 8'h00, 7'd0, 5'd1);
      send_request(CMD_PUT, NEWLINE_CHAR, 7'd0, 5'd0);
   endtask

   // Scroll twice from the last row: once by wrapping, once by a newline.
   // Column 0 must travel up with the rest and the last row must be blanked
   // with the new colours.
   task automatic test_scroll();
      drain_reports();
      write_colours(4'h0, 4'hF);
      send_request(CMD_SET, 8'h00, 7'd0, LINE_MAX - 5'd1);
      send_request(CMD_PUT, 8'h31, 7'd0, 5'd0);
      send_request(CMD_SET, 8'h00, COL_MAX, LINE_MAX);
      send_request(CMD_PUT, 8'h32, 7'd0, 5'd0);
      send_request(CMD_PUT, 8'h33, 7'd0, 5'd0);
      send_request(CMD_PUT, NEWLINE_CHAR, 7'd0, 5'd0);
      send_request(CMD_READ, 8'h00, 7'd0, LINE_MAX - 5'd3);
      send_request(CMD_READ, 8'h00, COL_MAX, LINE_MAX - 5'd2);
      send_request(CMD_READ, 8'h00, 7'd0, LINE_MAX);
   endtask

   // Clear with swapped colour extremes, then clamp a cursor move to the far
   // corner and write there.
   task automatic test_clear_and_clamp();
      drain_reports();
      write_colours(4'hF, 4'h0);
      send_request(CMD_CLEAR, 8'hFF, 7'h7F, 5'h1F);
      send_request(CMD_SET, 8'h00, 7'h7F, 5'h1F);
      send_request(CMD_READ, 8'h00, 7'd40, 5'd12);
      send_request(CMD_PUT, 8'h80, 7'd0, 5'd0);
      send_request(CMD_READ, 8'h00, 7'h7F, 5'h1F);
   endtask

   // One burst of random traffic. Mostly cursor moves followed by typed runs,
   // aimed near the right edge and the last row so wraps and scrolls happen
   // often; the rest is reads, stray moves and the odd clear.
   task automatic run_random_scene();
      int                pick;
      int                length;
      logic [COL_W-1:0]  col;
      logic [LINE_W-1:0] row;
      pick    = $urandom_range(0, 99);
      no_gaps = ($urandom_range(0, 3) == 0);
      if (pick < 3) begin
         send_request(CMD_CLEAR, 8'($urandom), 7'($urandom), 5'($urandom));
      end else if (pick < 60) begin
         if (pick < 45) begin
            case ($urandom_range(0, 3))
               0: col = 7'($urandom);
               1, 2: col = 7'($urandom_range(COLUMNS - 20, COLUMNS - 1));
               default: col = '0;
            endcase
            row = ($urandom_range(0, 1) == 0) ? LINE_MAX : 5'($urandom);
            send_request(CMD_SET, 8'($urandom), col, row);
         end
         length = $urandom_range(1, 24);
         repeat (length) begin
            send_request(CMD_PUT,
                         ($urandom_range(0, 9) == 0) ? NEWLINE_CHAR : 8'($urandom),
                         7'($urandom), 5'($urandom));
         end
      end else if (pick < 90) begin
         length = $urandom_range(1, 6);
         repeat (length) begin
            // half the reads look just behind the cursor at freshly typed cells
            if ($urandom_range(0, 1) == 0) begin
               col = (model_col > 7'd2) ? model_col - 7'($urandom_range(1, 3)) : '0;
               row = model_line;
            end else begin
               col = 7'($urandom);
               row = 5'($urandom);
            end
            send_request(CMD_READ, 8'($urandom), col, row);
         end
      end else begin
         send_request(CMD_SET, 8'($urandom), 7'($urandom), 5'($urandom));
      end
   endtask

   // Four phases of random scenes, each under its own colour setting; the
   // first two take the all-ones and all-zeros extremes.
   task automatic test_random_traffic();
      int target;
      for (int phase = 0; phase < 4; phase++) begin
         drain_reports();
         case (phase)
            0: write_colours('1, '1);
            1: write_colours('0, '0);
            default: write_colours(4'($urandom), 4'($urandom));
         endcase
         target = requests_sent + RANDOM_ITEMS / 4;
         while (requests_sent < target) run_random_scene();
      end
      no_gaps = 1'b0;
   endtask

   // ------------------------------------------------------------------
   // Clock, checker and watchdog
   // ------------------------------------------------------------------

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic compare_field(input string       name,
                                input logic [15:0] want,
                                input logic [15:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      end
   endtask

   // Each strobe carries one report; match it against the oldest owed one.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (expected_reports.size() == 0) begin
            errors++;
            $display("%0t: report with none owed, got %p", $time, rsp_payload);
         end else begin
            want = expected_reports.pop_front();
            compare_field("cursor_column_out", want.cursor_column_out,
                          rsp_payload.cursor_column_out);
            compare_field("cursor_line_out", want.cursor_line_out,
                          rsp_payload.cursor_line_out);
            compare_field("cursor_offset", want.cursor_offset,
                          rsp_payload.cursor_offset);
            compare_field("read_character", want.read_character,
                          rsp_payload.read_character);
            compare_field("read_attribute", want.read_attribute,
                          rsp_payload.read_attribute);
         end
      end
   end

   // Count cycles in which neither a request nor a report moves.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
         $display("text_console_cell_writer: mismatch");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------

   initial begin
      reset       <= 1'b1;
      start       <= 1'b0;
      req_payload <= '0;
      csr_we      <= 1'b0;
      csr_index   <= CSR_FOREGROUND;
      csr_wdata   <= '0;
      for (int i = 0; i < CELLS; i++) begin
         screen_char[i] = '0;
         screen_attr[i] = '0;
      end
      model_col  = '0;
      model_line = '0;
      fg_colour  = FG_RESET;
      bg_colour  = BG_RESET;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // the power-up clearing pass holds busy high; the first request waits it out
      test_reset_state();
      test_line_wrap();
      test_scroll();
      test_clear_and_clamp();
      test_random_traffic();
      drain_reports();

      $display("Ran %0d requests: %0d puts with %0d newlines, %0d wraps and %0d scrolls,",
               requests_sent, puts_done, newlines_done, wraps_done, scrolls_done);
      $display("%0d clears, %0d cursor moves, %0d cell reads, %0d colour settings.",
               clears_done, sets_done, reads_done, colour_writes);
      if (errors == 0) begin
         $display("text_console_cell_writer: match");
      end else begin
         $display("text_console_cell_writer: mismatch");
      end
      $finish;
   end

endmodule
